// ----- hw/rtl/wtosc_pkg.sv -----
// wtosc_pkg: shared types and constants for the wavetable oscillator mixer
// no dependencies; used by every module under hw/rtl by scoped names
package wtosc_pkg;

    // config port geometry: five 32-bit registers at byte addresses 4*i
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // 16-bit audio limits
    localparam logic signed [15:0] PEAK_POS = 16'sh7fff;
    localparam logic signed [15:0] PEAK_NEG = 16'sh8000;

    // register indexes, paddr[4:2]
    typedef enum logic [2:0] {
        REG_ENABLED     = 3'd0,
        REG_WAVEFORM    = 3'd1,
        REG_PHASE_STEP  = 3'd2,
        REG_DUTY        = 3'd3,
        REG_GAIN        = 3'd4
    } t_reg_idx;

    // waveform select codes
    localparam logic WAVE_TRIANGLE = 1'b0;
    localparam logic WAVE_PULSE    = 1'b1;

    typedef struct packed {
        logic        enabled;
        logic        waveform;
        logic [23:0] phase_step;
        logic [7:0]  duty;
        logic [15:0] gain;
    } t_cfg;

    // word held between the oscillator stage and the mix stage
    typedef struct packed {
        logic               en;
        logic signed [15:0] mix;
        logic signed [15:0] wave;
    } t_voice;

endpackage

// ----- hw/rtl/wtosc_cfg.sv -----
// wtosc_cfg: APB-style register file for the oscillator settings
// depends on wtosc_pkg (t_cfg, register indexes, port widths)
module wtosc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wtosc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [wtosc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [wtosc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output wtosc_pkg::t_cfg                     o_cfg
);

    wtosc_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [2:0]      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[wtosc_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled     <= 1'b0;
            r_cfg.waveform    <= wtosc_pkg::WAVE_TRIANGLE;
            r_cfg.phase_step  <= '0;
            r_cfg.duty        <= 8'd128;
            r_cfg.gain        <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                wtosc_pkg::REG_ENABLED:     r_cfg.enabled     <= pwdata[0];
                wtosc_pkg::REG_WAVEFORM:    r_cfg.waveform    <= pwdata[0];
                wtosc_pkg::REG_PHASE_STEP:  r_cfg.phase_step  <= pwdata[23:0];
                wtosc_pkg::REG_DUTY:        r_cfg.duty        <= pwdata[7:0];
                wtosc_pkg::REG_GAIN:        r_cfg.gain        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            wtosc_pkg::REG_ENABLED:     prdata = 32'(r_cfg.enabled);
            wtosc_pkg::REG_WAVEFORM:    prdata = 32'(r_cfg.waveform);
            wtosc_pkg::REG_PHASE_STEP:  prdata = 32'(r_cfg.phase_step);
            wtosc_pkg::REG_DUTY:        prdata = 32'(r_cfg.duty);
            wtosc_pkg::REG_GAIN:        prdata = 32'(r_cfg.gain);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/wtosc_osc.sv -----
// wtosc_osc: phase accumulator and triangle / pulse waveform stage
// depends on wtosc_pkg (t_cfg, t_voice, peak constants)
module wtosc_osc #(
    parameter int TABLE_LENGTH    = 256,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic signed [15:0] i_mix,
    input  wtosc_pkg::t_cfg    i_cfg,
    output wtosc_pkg::t_voice  o_voice
);

    // table length is a power of two, so the phase wraps by truncation
    localparam int IDX_W = $clog2(TABLE_LENGTH);
    localparam int AW    = IDX_W + PHASE_FRAC_BITS;
    localparam int SW    = ((AW > 24) ? AW : 24) + 1;
    localparam int CW    = (IDX_W > 8) ? IDX_W : 8;
    localparam int SLOPE = (4 * 32767) / TABLE_LENGTH;

    localparam logic [IDX_W-1:0] QTR_OFF  = IDX_W'(TABLE_LENGTH - TABLE_LENGTH / 4);
    localparam logic [IDX_W:0]   HALF_LEN = (IDX_W + 1)'(TABLE_LENGTH / 2);
    localparam logic [16:0]      SLOPE_V  = 17'(SLOPE);
    localparam logic [CW-1:0]    LAST_IDX = CW'(TABLE_LENGTH - 1);

    logic [AW-1:0]      r_phase;
    logic [AW-1:0]      n_phase;
    logic [SW-1:0]      phase_sum;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W:0]     diff;
    logic [IDX_W-1:0]   tri_dev;
    logic [16:0]        ramp;
    logic [16:0]        tri_full;
    logic [CW-1:0]      pw_ext;
    logic [CW-1:0]      pw_lim;
    logic signed [15:0] wave;
    wtosc_pkg::t_voice  r_voice;

    assign phase_sum = SW'(r_phase) + SW'(i_cfg.phase_step);
    assign n_phase   = i_cfg.enabled ? phase_sum[AW-1:0] : r_phase;
    assign idx       = n_phase[AW-1:PHASE_FRAC_BITS];

    // triangle: slope * |((t + 3L/4) mod L) - L/2| - peak
    assign pos      = idx + QTR_OFF;
    assign diff     = {1'b0, pos} - HALF_LEN;
    assign tri_dev  = diff[IDX_W] ? IDX_W'(-diff) : diff[IDX_W-1:0];
    assign ramp     = 17'(17'(tri_dev) * SLOPE_V);
    assign tri_full = ramp - 17'(32767);

    // pulse width clamped to the last table entry
    assign pw_ext = CW'(i_cfg.duty);
    assign pw_lim = (pw_ext > LAST_IDX) ? LAST_IDX : pw_ext;

    always_comb begin
        if (i_cfg.waveform == wtosc_pkg::WAVE_PULSE) begin
            wave = (CW'(idx) <= pw_lim) ? wtosc_pkg::PEAK_POS : wtosc_pkg::PEAK_NEG;
        end else begin
            wave = tri_full[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_voice.en   <= i_cfg.enabled;
            r_voice.mix  <= i_mix;
            r_voice.wave <= wave;
        end
    end

    assign o_voice = r_voice;

endmodule

// ----- hw/rtl/wtosc_mix.sv -----
// wtosc_mix: gain multiply, truncation toward zero and saturating mix add
// depends on wtosc_pkg (t_voice, peak constants)
module wtosc_mix (
    input  logic               i_clk,
    input  logic               i_load,
    input  wtosc_pkg::t_voice  i_voice,
    input  logic [15:0]        i_gain,
    output logic signed [15:0] o_mix_out
);

    logic signed [32:0] prod;
    logic signed [32:0] biased;
    logic signed [32:0] quot;
    logic signed [15:0] scaled;
    logic signed [16:0] sum;
    logic signed [15:0] n_out;
    logic signed [15:0] r_out;

    assign prod   = 33'(i_voice.wave) * $signed({17'd0, i_gain});
    // bias negatives so the arithmetic shift rounds toward zero
    assign biased = prod + (prod[32] ? 33'sd255 : 33'sd0);
    assign quot   = biased >>> 8;

    always_comb begin
        if (quot > 33'sd32767) begin
            scaled = wtosc_pkg::PEAK_POS;
        end else if (quot < -33'sd32768) begin
            scaled = wtosc_pkg::PEAK_NEG;
        end else begin
            scaled = quot[15:0];
        end
    end

    assign sum = 17'(i_voice.mix) + 17'(scaled);

    always_comb begin
        if (!i_voice.en) begin
            n_out = i_voice.mix;
        end else if (sum > 17'sd32767) begin
            n_out = wtosc_pkg::PEAK_POS;
        end else if (sum < -17'sd32768) begin
            n_out = wtosc_pkg::PEAK_NEG;
        end else begin
            n_out = sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_mix_out = r_out;

endmodule

// ----- hw/rtl/wavetable_oscillator_mixer.sv -----
// wavetable_oscillator_mixer: wavetable-style oscillator added into a running mix
// an accepted input word is registered in the oscillator stage, then in the output register
// throughput: one word per cycle while the output is not stalled; the oscillator and mix stages each hold one word
// reset (synchronous, i_rst_n low): pipeline empty, phase zero, registers to defaults
// depends on wtosc_pkg, wtosc_cfg, wtosc_osc, wtosc_mix
module wavetable_oscillator_mixer #(
    parameter int TABLE_LENGTH    = 256,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_mix_in_valid,
    output logic                                o_mix_in_stall,
    input  logic signed [15:0]                  i_mix_in,
    // output channel
    output logic                                o_mix_out_valid,
    input  logic                                i_mix_out_stall,
    output logic signed [15:0]                  o_mix_out,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wtosc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [wtosc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [wtosc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);

    wtosc_pkg::t_cfg   cfg;
    wtosc_pkg::t_voice voice;

    logic r_v1;      // oscillator stage holds a word
    logic r_v2;      // output register holds a word
    logic adv2;      // output register may load
    logic adv1;      // oscillator stage may load
    logic in_acc;

    // a stage loads when it is empty or the stage after it moves on
    assign adv2   = !r_v2 || !i_mix_out_stall;
    assign adv1   = !r_v1 || adv2;
    assign in_acc = i_mix_in_valid && adv1;

    assign o_mix_in_stall  = !adv1;
    assign o_mix_out_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_mix_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    wtosc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // phase advances only for accepted words while enabled
    wtosc_osc #(
        .TABLE_LENGTH    (TABLE_LENGTH),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_osc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_mix   (i_mix_in),
        .i_cfg   (cfg),
        .o_voice (voice)
    );

    // gain scaling and saturating add into the output register
    wtosc_mix u_mix (
        .i_clk     (i_clk),
        .i_load    (adv2 && r_v1),
        .i_voice   (voice),
        .i_gain    (cfg.gain),
        .o_mix_out (o_mix_out)
    );

    // an empty oscillator stage never pushes back on the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_mix_in_stall)
        else $error("input stalled with empty oscillator stage");

    // a word accepted while disabled is marked for pass-through
    a_bypass_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg.enabled) |=> (r_v1 && !voice.en))
        else $error("disabled word not marked for pass-through");

    // a word in the oscillator stage reaches the output when the output is free
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2) |=> o_mix_out_valid)
        else $error("oscillator stage word lost on the way out");

endmodule

// ----- bench/tb_wavetable_oscillator_mixer.sv -----
// tb_wavetable_oscillator_mixer: self-checking bench for the wavetable oscillator mixer
// drives sample words and apb register writes and reads, predicts every output word and compares
// depends on wtosc_pkg and wavetable_oscillator_mixer
module tb_wavetable_oscillator_mixer;

    localparam int TBL_LEN       = 256;
    localparam int FRAC_BITS     = 16;
    localparam int TRI_SLOPE     = (4 * int'(wtosc_pkg::PEAK_POS)) / TBL_LEN;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ROUNDS = 12;

    // clock, reset and dut ports; every input known from time zero
    logic                                   i_clk           = 1'b0;
    logic                                   i_rst_n         = 1'b0;
    logic                                   i_mix_in_valid  = 1'b0;
    logic                                   o_mix_in_stall;
    logic signed [15:0]                     i_mix_in        = '0;
    logic                                   o_mix_out_valid;
    logic                                   i_mix_out_stall = 1'b0;
    logic signed [15:0]                     o_mix_out;
    logic                                   psel            = 1'b0;
    logic                                   penable         = 1'b0;
    logic                                   pwrite          = 1'b0;
    logic [wtosc_pkg::CFG_ADDR_W-1:0]       paddr           = '0;
    logic [wtosc_pkg::CFG_DATA_W-1:0]       pwdata          = '0;
    logic [wtosc_pkg::CFG_DATA_W-1:0]       prdata;
    logic                                   pready;

    // shadow of the oscillator: registers and phase accumulator
    wtosc_pkg::t_cfg        voice_cfg;
    logic [23:0]            osc_phase;

    // sample words waiting to be sent, mixed words waiting to come out
    logic signed [15:0]     pend_words[$];
    logic signed [15:0]     mix_due[$];
    logic signed [15:0]     due_word;

    // handshake bookkeeping shared between the edge blocks
    bit                     in_took  = 1'b0;
    bit                     calm     = 1'b0;
    int                     in_gap   = 0;
    int                     out_hold = 0;

    int                     mis_count   = 0;
    int                     words_in    = 0;
    int                     words_out   = 0;
    int                     voiced      = 0;
    int                     rail_hits   = 0;
    int                     reg_reads   = 0;
    int                     settings    = 0;
    int                     cycle_count = 0;

    wavetable_oscillator_mixer #(
        .TABLE_LENGTH    (TBL_LEN),
        .PHASE_FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mix_in_valid  (i_mix_in_valid),
        .o_mix_in_stall  (o_mix_in_stall),
        .i_mix_in        (i_mix_in),
        .o_mix_out_valid (o_mix_out_valid),
        .i_mix_out_stall (i_mix_out_stall),
        .o_mix_out       (o_mix_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 12-unit clock, low then high
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // saturate to the signed 16-bit range
    function automatic longint clip16(input longint v);
        if (v > wtosc_pkg::PEAK_POS) return wtosc_pkg::PEAK_POS;
        if (v < wtosc_pkg::PEAK_NEG) return wtosc_pkg::PEAK_NEG;
        return v;
    endfunction

    // advance the oscillator by one sample and return the mixed word
    function automatic logic signed [15:0] next_mix(input logic signed [15:0] smp);
        int     idx;
        int     pos;
        int     dev;
        int     pw;
        int     wave;
        longint scaled;
        longint sum;
        // voice off: sample passes straight through, phase frozen
        if (!voice_cfg.enabled) return smp;
        voiced++;
        // 24-bit accumulator spans exactly the table, so the add wraps by itself
        osc_phase = osc_phase + voice_cfg.phase_step;
        idx = int'(osc_phase >> FRAC_BITS);
        if (voice_cfg.waveform == wtosc_pkg::WAVE_PULSE) begin
            // width past the last entry keeps the pulse high everywhere
            pw = voice_cfg.duty;
            if (pw > TBL_LEN - 1) pw = TBL_LEN - 1;
            wave = (idx <= pw) ? wtosc_pkg::PEAK_POS : wtosc_pkg::PEAK_NEG;
        end else begin
            // triangle, peak at a quarter of the table, trough at three quarters
            pos = (idx + TBL_LEN - TBL_LEN / 4) % TBL_LEN;
            dev = pos - TBL_LEN / 2;
            if (dev < 0) dev = -dev;
            wave = TRI_SLOPE * dev - wtosc_pkg::PEAK_POS;
        end
        // q8.8 gain, signed divide truncates toward zero
        scaled = longint'(wave) * longint'(voice_cfg.gain) / 256;
        sum    = longint'(smp) + clip16(scaled);
        return 16'(clip16(sum));
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // sample word biased toward the rails and the values around zero
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return wtosc_pkg::PEAK_POS;
            1:       return wtosc_pkg::PEAK_NEG;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // register write data: random upper bits, field often all ones or all zeros
    function automatic logic [31:0] pick_reg(input int w);
        logic [31:0] v;
        logic [31:0] ones;
        v    = $urandom;
        ones = (32'h1 << w) - 32'h1;
        case ($urandom_range(5))
            0:       v = v | ones;
            1:       v = v & ~ones;
            default: ;
        endcase
        return v;
    endfunction

    task automatic note_miss(input string msg);
        mis_count++;
        if (mis_count <= 10) $display("mismatch: %s", msg);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic reg_write(input wtosc_pkg::t_reg_idx r, input logic [31:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low bits of each register survive
        case (r)
            wtosc_pkg::REG_ENABLED:    voice_cfg.enabled    = d[0];
            wtosc_pkg::REG_WAVEFORM:   voice_cfg.waveform   = d[0];
            wtosc_pkg::REG_PHASE_STEP: voice_cfg.phase_step = d[23:0];
            wtosc_pkg::REG_DUTY:       voice_cfg.duty       = d[7:0];
            wtosc_pkg::REG_GAIN:       voice_cfg.gain       = d[15:0];
            default:                   ;
        endcase
    endtask

    // apb read, compared with the shadow register
    task automatic reg_check(input wtosc_pkg::t_reg_idx r);
        logic [31:0] want;
        case (r)
            wtosc_pkg::REG_ENABLED:    want = 32'(voice_cfg.enabled);
            wtosc_pkg::REG_WAVEFORM:   want = 32'(voice_cfg.waveform);
            wtosc_pkg::REG_PHASE_STEP: want = 32'(voice_cfg.phase_step);
            wtosc_pkg::REG_DUTY:       want = 32'(voice_cfg.duty);
            default:                   want = 32'(voice_cfg.gain);
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_reads++;
        if (prdata !== want)
            note_miss($sformatf("register %s read %h, expected %h", r.name(), prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_all_regs();
        wtosc_pkg::t_reg_idx r;
        r = r.first();
        forever begin
            reg_check(r);
            if (r == r.last()) break;
            r = r.next();
        end
    endtask

    // every word sent and every mixed word back
    task automatic wait_idle();
        while (!(pend_words.size() == 0 && !i_mix_in_valid && mix_due.size() == 0))
            @(posedge i_clk);
    endtask

    // one random register setting followed by a burst of sample words
    task automatic random_round(input int n);
        logic [31:0] v;
        // voice on most of the time
        v    = $urandom;
        v[0] = ($urandom_range(3) != 0);
        reg_write(wtosc_pkg::REG_ENABLED, v);
        reg_write(wtosc_pkg::REG_WAVEFORM, pick_reg(1));
        // slow sweeps now and then, otherwise any step at all
        if ($urandom_range(3) == 0) v = $urandom_range(32'h0002_ffff);
        else v = pick_reg(24);
        reg_write(wtosc_pkg::REG_PHASE_STEP, v);
        reg_write(wtosc_pkg::REG_DUTY, pick_reg(8));
        reg_write(wtosc_pkg::REG_GAIN, pick_reg(16));
        check_all_regs();
        settings++;
        calm = ($urandom_range(3) == 0);
        repeat (n) pend_words.push_back(pick_sample());
        wait_idle();
    endtask

    // sender: holds a stalled word, loads the next after its gap
    always @(negedge i_clk) begin
        if (!i_mix_in_valid || in_took) begin
            if (in_gap > 0) begin
                in_gap--;
                i_mix_in_valid <= 1'b0;
            end else if (pend_words.size() > 0) begin
                i_mix_in       <= pend_words.pop_front();
                i_mix_in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                i_mix_in_valid <= 1'b0;
            end
        end
        // receiver: stall runs of random length
        if (out_hold > 0) begin
            out_hold--;
            i_mix_out_stall <= 1'b1;
        end else begin
            out_hold = pick_gap();
            i_mix_out_stall <= (out_hold > 0);
            if (out_hold > 0) out_hold--;
        end
    end

    // monitor: predict on every accepted input word, check every accepted output word
    always @(posedge i_clk) begin
        in_took = i_rst_n && i_mix_in_valid && !o_mix_in_stall;
        if (in_took) begin
            due_word = next_mix(i_mix_in);
            if (due_word == wtosc_pkg::PEAK_POS || due_word == wtosc_pkg::PEAK_NEG)
                rail_hits++;
            mix_due.push_back(due_word);
            words_in++;
        end
        if (i_rst_n && o_mix_out_valid && !i_mix_out_stall) begin
            words_out++;
            if (mix_due.size() == 0) begin
                note_miss($sformatf("word %0d (%0d) arrived with none expected",
                                    words_out, o_mix_out));
            end else begin
                due_word = mix_due.pop_front();
                if (o_mix_out !== due_word)
                    note_miss($sformatf("word %0d: expected %0d, got %0d",
                                        words_out, due_word, o_mix_out));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, mix_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // reset state of the shadow
        voice_cfg.enabled    = 1'b0;
        voice_cfg.waveform   = wtosc_pkg::WAVE_TRIANGLE;
        voice_cfg.phase_step = '0;
        voice_cfg.duty       = 8'd128;
        voice_cfg.gain       = '0;
        osc_phase            = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values read back, then pass-through with the voice off
        check_all_regs();
        settings++;
        pend_words.push_back(wtosc_pkg::PEAK_POS);
        pend_words.push_back(wtosc_pkg::PEAK_NEG);
        pend_words.push_back(16'sd0);
        pend_words.push_back(-16'sd1);
        pend_words.push_back(16'sh5555);
        pend_words.push_back(-16'sd21846);
        wait_idle();

        // triangle at full gain: scaled value clips, sum overflows the positive rail
        reg_write(wtosc_pkg::REG_ENABLED, 32'h0000_0001);
        reg_write(wtosc_pkg::REG_PHASE_STEP, 32'h0001_0000);
        reg_write(wtosc_pkg::REG_GAIN, 32'h0000_ffff);
        settings++;
        pend_words.push_back(wtosc_pkg::PEAK_POS);
        pend_words.push_back(wtosc_pkg::PEAK_NEG);
        pend_words.push_back(16'sd0);
        pend_words.push_back(16'sd1000);
        pend_words.push_back(-16'sd1000);
        pend_words.push_back(16'sd0);
        wait_idle();

        // pulse, width at the last table entry, step one short of a full wrap;
        // all-ones writes check that only the field bits are kept
        reg_write(wtosc_pkg::REG_WAVEFORM, 32'hffff_ffff);
        reg_write(wtosc_pkg::REG_DUTY, 32'hffff_ffff);
        reg_write(wtosc_pkg::REG_PHASE_STEP, 32'hffff_ffff);
        reg_write(wtosc_pkg::REG_GAIN, 32'h0000_0100);
        check_all_regs();
        settings++;
        pend_words.push_back(wtosc_pkg::PEAK_POS);
        pend_words.push_back(wtosc_pkg::PEAK_NEG);
        pend_words.push_back(16'sd0);
        pend_words.push_back(-16'sd1);
        wait_idle();

        // narrowest pulse, half-table step, small gain
        reg_write(wtosc_pkg::REG_DUTY, 32'h0000_0000);
        reg_write(wtosc_pkg::REG_PHASE_STEP, 32'h0080_0000);
        reg_write(wtosc_pkg::REG_GAIN, 32'h0000_0040);
        settings++;
        repeat (5) pend_words.push_back(pick_sample());
        wait_idle();

        // voice on with zero step and zero gain
        reg_write(wtosc_pkg::REG_PHASE_STEP, 32'h0000_0000);
        reg_write(wtosc_pkg::REG_GAIN, 32'h0000_0000);
        settings++;
        repeat (3) pend_words.push_back(pick_sample());
        wait_idle();

        // random register settings, each with a burst of words
        repeat (RANDOM_ROUNDS) random_round($urandom_range(70, 30));

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("covered %0d words (%0d voiced) over %0d register settings, %0d reads",
                 words_in, voiced, settings, reg_reads);
        $display("%0d mixed words at a 16-bit rail, %0d mismatches", rail_hits, mis_count);
        if (mis_count == 0 && mix_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wtosc_pkg.sv
hw/rtl/wtosc_cfg.sv
hw/rtl/wtosc_osc.sv
hw/rtl/wtosc_mix.sv
hw/rtl/wavetable_oscillator_mixer.sv
bench/tb_wavetable_oscillator_mixer.sv
